[src/pgfs_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and the gap merge rule for the partition gap fit selector.
// No dependencies; the other files but pgfs_chan_if refer to this package by scoped names.
package pgfs_pkg;

   localparam int INPUT_SLOTS = 4;   // slots that arrive with each request
   localparam int LEAF_COUNT  = 8;   // leaves of the selection tree (three levels)
   localparam int SIZE_W      = 31;  // byte counts and offsets on the request side
   localparam int START_W     = 32;  // gap start, slot start plus size
   localparam int DIFF_W      = 34;  // signed gap length
   localparam int HEADER_W    = 16;
   localparam int CSR_INDEX_W = 2;

   typedef enum logic [1:0] {
      FIT_FIRST = 2'd0,
      FIT_BEST  = 2'd1,
      FIT_WORST = 2'd2,
      FIT_NONE  = 2'd3
   } fit_mode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_HEADER_SIZE = 2'd0,
      CSR_DISK_SIZE   = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic               fit;
      logic [SIZE_W-1:0]  len;
      logic [START_W-1:0] start;
   } gap_type;

   typedef struct packed {
      logic               found;
      logic [START_W-1:0] gap_start;
   } result_type;

   typedef struct packed {
      logic                         valid;
      fit_mode_type                 mode;
      gap_type [LEAF_COUNT-1:0]     leaf;
   } select_in_type;

   typedef struct packed {
      logic       valid;
      result_type result;
   } select_out_type;

   // Merge two candidates; the early one wins ties.
   function automatic gap_type fit_merge(fit_mode_type mode, gap_type early, gap_type late);
      gap_type pick;
      pick = early;
      if (!early.fit) begin
         pick = late;
      end else if (late.fit) begin
         case (mode)
            FIT_BEST: begin
               if (late.len < early.len) pick = late;
            end
            FIT_WORST: begin
               if (late.len > early.len) pick = late;
            end
            default: begin
               pick = early;
            end
         endcase
      end
      return pick;
   endfunction

endpackage

[src/pgfs_chan_if.sv]
`timescale 1ns / 1ps
// Request and response channel interfaces of the partition gap fit selector.
// Depends on nothing; widths match the fields in pgfs_pkg.
interface pgfs_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [30:0] request_size;
   logic [30:0] slot0_start;
   logic [30:0] slot0_size;
   logic [30:0] slot1_start;
   logic [30:0] slot1_size;
   logic [30:0] slot2_start;
   logic [30:0] slot2_size;
   logic [30:0] slot3_start;
   logic [30:0] slot3_size;

   modport source (
      output valid, cmd, request_size,
      output slot0_start, slot0_size, slot1_start, slot1_size,
      output slot2_start, slot2_size, slot3_start, slot3_size,
      input  ready
   );
   modport sink (
      input  valid, cmd, request_size,
      input  slot0_start, slot0_size, slot1_start, slot1_size,
      input  slot2_start, slot2_size, slot3_start, slot3_size,
      output ready
   );
endinterface

interface pgfs_rsp_if;
   logic        valid;
   logic        ready;
   logic        found;
   logic [31:0] gap_start;

   modport source (output valid, found, gap_start, input ready);
   modport sink (input valid, found, gap_start, output ready);
endinterface

[src/pgfs_select.sv]
`timescale 1ns / 1ps
// Three-level registered selection tree that picks one gap out of the candidates.
// Depends on pgfs_pkg (gap_type, fit_merge, select structs).
module pgfs_select (
   input  logic                     clock,
   input  logic                     reset,
   input  pgfs_pkg::select_in_type  sel_in,
   output logic                     sel_in_ready,
   output pgfs_pkg::select_out_type sel_out,
   input  logic                     sel_out_ready
);

   localparam int L1_COUNT = pgfs_pkg::LEAF_COUNT / 2;
   localparam int L2_COUNT = L1_COUNT / 2;

   logic v1_ff, v2_ff, v3_ff;
   logic en1, en2, en3;
   pgfs_pkg::fit_mode_type mode1_ff, mode2_ff;
   pgfs_pkg::gap_type [L1_COUNT-1:0] lvl1_ff, lvl1_in;
   pgfs_pkg::gap_type [L2_COUNT-1:0] lvl2_ff, lvl2_in;
   pgfs_pkg::gap_type                root_ff, root_in;

   // Advance a level when the next one is empty or moving too.
   assign en3          = !v3_ff || sel_out_ready;
   assign en2          = !v2_ff || en3;
   assign en1          = !v1_ff || en2;
   assign sel_in_ready = en1;

   always_comb begin
      for (int i = 0; i < L1_COUNT; i++) begin
         lvl1_in[i] = pgfs_pkg::fit_merge(sel_in.mode, sel_in.leaf[2*i], sel_in.leaf[2*i+1]);
      end
      for (int i = 0; i < L2_COUNT; i++) begin
         lvl2_in[i] = pgfs_pkg::fit_merge(mode1_ff, lvl1_ff[2*i], lvl1_ff[2*i+1]);
      end
      root_in = pgfs_pkg::fit_merge(mode2_ff, lvl2_ff[0], lvl2_ff[L2_COUNT-1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= sel_in.valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         lvl1_ff  <= lvl1_in;
         mode1_ff <= sel_in.mode;
      end
      if (en2) begin
         lvl2_ff  <= lvl2_in;
         mode2_ff <= mode1_ff;
      end
      if (en3) begin
         root_ff <= root_in;
      end
   end

   assign sel_out.valid            = v3_ff;
   assign sel_out.result.found     = root_ff.fit;
   assign sel_out.result.gap_start = root_ff.fit ? root_ff.start : '0;

endmodule

[src/partition_gap_fit_selector.sv]
`timescale 1ns / 1ps
// Top level of the partition gap fit selector: config registers, gap pipeline, tree.
// Depends on pgfs_pkg, pgfs_chan_if (pgfs_req_if, pgfs_rsp_if) and pgfs_select.

// The block takes one request per clock while the response side does not stall and
// returns one response per request, in order. A request passes through six register
// stages: slot end sums, the cursor chain with gap lengths, the fit test against the
// requested size, and three levels of the selection tree. Each stage holds under
// back-pressure and takes a new request as soon as its successor frees up, so bubbles
// collapse and nothing is dropped. header_size (index 0, reset 256) and disk_size
// (index 1, reset 0) are to be written by the user through the csr port only while no
// request is in flight; the block does not enforce this. Writes to other indexes are
// ignored. Slots past SLOT_COUNT, or past the four that arrive, are treated as
// unused. A cmd value of 3 yields found 0 and gap_start 0.
module partition_gap_fit_selector #(
   parameter int SLOT_COUNT = 4
) (
   input  logic              clock,
   input  logic              reset,
   pgfs_req_if.sink          req_chan,
   pgfs_rsp_if.source        rsp_chan,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [30:0]       csr_wdata
);

   localparam int ACTIVE_SLOTS = (SLOT_COUNT < pgfs_pkg::INPUT_SLOTS) ?
                                 SLOT_COUNT : pgfs_pkg::INPUT_SLOTS;
   localparam int GAP_COUNT    = ACTIVE_SLOTS + 1;

   // ---------------------------------------------------------------- registers
   logic [pgfs_pkg::HEADER_W-1:0] header_size_ff;
   logic [pgfs_pkg::SIZE_W-1:0]   disk_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         header_size_ff <= 16'd256;
         disk_size_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            pgfs_pkg::CSR_HEADER_SIZE: header_size_ff <= csr_wdata[pgfs_pkg::HEADER_W-1:0];
            pgfs_pkg::CSR_DISK_SIZE:   disk_size_ff   <= csr_wdata;
            default: begin
               // drop writes past the register list
            end
         endcase
      end
   end

   // ---------------------------------------------------------------- request fields
   logic [pgfs_pkg::INPUT_SLOTS-1:0][pgfs_pkg::SIZE_W-1:0] in_start, in_size;

   assign in_start[0] = req_chan.slot0_start;
   assign in_start[1] = req_chan.slot1_start;
   assign in_start[2] = req_chan.slot2_start;
   assign in_start[3] = req_chan.slot3_start;
   assign in_size[0]  = req_chan.slot0_size;
   assign in_size[1]  = req_chan.slot1_size;
   assign in_size[2]  = req_chan.slot2_size;
   assign in_size[3]  = req_chan.slot3_size;

   // ---------------------------------------------------------------- stall control
   logic en1, en2, en3;
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic sel_in_ready;

   // Advance a stage when the next one is empty or moving too.
   assign en3            = !s3_valid_ff || sel_in_ready;
   assign en2            = !s2_valid_ff || en3;
   assign en1            = !s1_valid_ff || en2;
   assign req_chan.ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (en1) s1_valid_ff <= req_chan.valid;
         if (en2) s2_valid_ff <= s1_valid_ff;
         if (en3) s3_valid_ff <= s2_valid_ff;
      end
   end

   // ---------------------------------------------------------------- stage 1
   // Form each slot's end (start plus size) and flag slots in use.
   pgfs_pkg::fit_mode_type                             s1_mode_ff;
   logic [pgfs_pkg::SIZE_W-1:0]                        s1_req_ff;
   logic [ACTIVE_SLOTS-1:0][pgfs_pkg::SIZE_W-1:0]      s1_start_ff;
   logic [ACTIVE_SLOTS-1:0][pgfs_pkg::START_W-1:0]     s1_end_ff;
   logic [ACTIVE_SLOTS-1:0]                            s1_used_ff;

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_mode_ff <= pgfs_pkg::fit_mode_type'(req_chan.cmd);
         s1_req_ff  <= req_chan.request_size;
         for (int i = 0; i < ACTIVE_SLOTS; i++) begin
            s1_start_ff[i] <= in_start[i];
            s1_end_ff[i]   <= {1'b0, in_start[i]} + {1'b0, in_size[i]};
            s1_used_ff[i]  <= (in_start[i] != '0);
         end
      end
   end

   // ---------------------------------------------------------------- stage 2
   // Walk the cursor across the slots and take each gap's signed length.
   pgfs_pkg::fit_mode_type                         s2_mode_ff;
   logic [pgfs_pkg::SIZE_W-1:0]                    s2_req_ff;
   logic [GAP_COUNT-1:0][pgfs_pkg::START_W-1:0]    s2_begin_ff, s2_begin_in;
   logic [GAP_COUNT-1:0][pgfs_pkg::DIFF_W-1:0]     s2_diff_ff, s2_diff_in;

   always_comb begin
      logic [pgfs_pkg::START_W-1:0] cursor;
      cursor = {{(pgfs_pkg::START_W - pgfs_pkg::HEADER_W){1'b0}}, header_size_ff};
      for (int i = 0; i < ACTIVE_SLOTS; i++) begin
         s2_begin_in[i] = cursor;
         s2_diff_in[i]  = {3'b000, s1_start_ff[i]} - {2'b00, cursor};
         if (s1_used_ff[i]) cursor = s1_end_ff[i];
      end
      // last gap runs up to the end of the disk
      s2_begin_in[GAP_COUNT-1] = cursor;
      s2_diff_in[GAP_COUNT-1]  = {3'b000, disk_size_ff} - {2'b00, cursor};
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         s2_mode_ff  <= s1_mode_ff;
         s2_req_ff   <= s1_req_ff;
         s2_begin_ff <= s2_begin_in;
         s2_diff_ff  <= s2_diff_in;
      end
   end

   // ---------------------------------------------------------------- stage 3
   // Test each gap: valid mode, positive and no shorter than the request. Pad the tree leaves.
   pgfs_pkg::fit_mode_type                             s3_mode_ff;
   pgfs_pkg::gap_type [pgfs_pkg::LEAF_COUNT-1:0]       s3_leaf_ff, s3_leaf_in;
   logic                                               s3_fit_any;

   always_comb begin
      s3_leaf_in = '0;
      for (int i = 0; i < GAP_COUNT; i++) begin
         s3_leaf_in[i].fit   = (s2_mode_ff != pgfs_pkg::FIT_NONE)
                             && !s2_diff_ff[i][pgfs_pkg::DIFF_W-1]
                             && (s2_diff_ff[i] != '0)
                             && (s2_diff_ff[i][pgfs_pkg::SIZE_W-1:0] >= s2_req_ff);
         s3_leaf_in[i].len   = s2_diff_ff[i][pgfs_pkg::SIZE_W-1:0];
         s3_leaf_in[i].start = s2_begin_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         s3_mode_ff <= s2_mode_ff;
         s3_leaf_ff <= s3_leaf_in;
      end
   end

   always_comb begin
      s3_fit_any = 1'b0;
      for (int i = 0; i < pgfs_pkg::LEAF_COUNT; i++) begin
         s3_fit_any = s3_fit_any | s3_leaf_ff[i].fit;
      end
   end

   // ---------------------------------------------------------------- stages 4 to 6
   pgfs_pkg::select_in_type  sel_in;
   pgfs_pkg::select_out_type sel_out;

   assign sel_in.valid = s3_valid_ff;
   assign sel_in.mode  = s3_mode_ff;
   assign sel_in.leaf  = s3_leaf_ff;

   pgfs_select u_select (
      .clock         (clock),
      .reset         (reset),
      .sel_in        (sel_in),
      .sel_in_ready  (sel_in_ready),
      .sel_out       (sel_out),
      .sel_out_ready (rsp_chan.ready)
   );

   assign rsp_chan.valid     = sel_out.valid;
   assign rsp_chan.found     = sel_out.result.found;
   assign rsp_chan.gap_start = sel_out.result.gap_start;

   // ---------------------------------------------------------------- assertions
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> s1_valid_ff)
      else $error("accepted request did not enter stage 1");

   a_stage2_holds: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !en2) |=> (s2_valid_ff && $stable(s2_begin_ff) && $stable(s2_diff_ff)))
      else $error("stalled stage 2 lost or changed its request");

   a_none_mode: assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && (s3_mode_ff == pgfs_pkg::FIT_NONE)) |-> !s3_fit_any)
      else $error("gap marked as fitting under an invalid mode");

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for partition_gap_fit_selector: directed tables, then random ones.
// Depends on pgfs_pkg, pgfs_chan_if and the selector RTL; predicts every response in-line.
module tb;

   // Pipeline depth, used by settle_idle with margin on top to let the pipeline empty.
   localparam int PIPE_LATENCY = 6;
   localparam int CYCLE_LIMIT  = 500000;
   localparam logic [1:0] CSR_SPARE_A = 2'd2;   // unmapped register indexes
   localparam logic [1:0] CSR_SPARE_B = 2'd3;
   localparam logic [30:0] BYTE_MAX   = 31'h7FFF_FFFF;

   typedef struct packed {
      pgfs_pkg::fit_mode_type cmd;
      logic [30:0]            request_size;
      logic [3:0][30:0]       slot_start;
      logic [3:0][30:0]       slot_size;
   } alloc_req_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [30:0] csr_wdata;

   pgfs_req_if req_bus ();
   pgfs_rsp_if rsp_bus ();

   partition_gap_fit_selector i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow copies of the two registers, updated on each CSR write to their index.
   logic [15:0] hdr_model;
   logic [30:0] disk_model;

   pgfs_pkg::result_type expected_gaps [$];
   pgfs_pkg::result_type want;
   int          mismatch_count = 0;
   int          cycle_count = 0;
   int unsigned stall_left = 0;
   bit          idle_on = 1'b0;

   always #2 clock = ~clock;

   // Abort a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   // Mostly no gap, some short ones, a few long ones.
   function automatic int unsigned idle_length();
      int unsigned pick;
      if (!idle_on) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      if (pick < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 50) $display("tb: mismatch at cycle %0d: %s", cycle_count, what);
   endtask

   // Walk the five candidate gaps with a 34-bit signed cursor and apply the fit rule.
   function automatic pgfs_pkg::result_type predict_gap_choice(input alloc_req_type r);
      pgfs_pkg::result_type res;
      logic signed [33:0]   cursor, lo, hi, len, want_len, best_len, best_lo;
      logic                 have;
      have     = 1'b0;
      best_len = '0;
      best_lo  = '0;
      cursor   = $signed({18'd0, hdr_model});
      want_len = $signed({3'd0, r.request_size});
      if (r.cmd != pgfs_pkg::FIT_NONE) begin
         for (int g = 0; g <= pgfs_pkg::INPUT_SLOTS; g++) begin
            lo = cursor;
            if (g < pgfs_pkg::INPUT_SLOTS) begin
               hi = $signed({3'd0, r.slot_start[g]});
               // An unused slot leaves the cursor where it was.
               if (r.slot_start[g] != '0) cursor = hi + $signed({3'd0, r.slot_size[g]});
            end else begin
               hi = $signed({3'd0, disk_model});
            end
            len = hi - lo;
            if (len > 0 && len >= want_len) begin
               if (!have) begin
                  have     = 1'b1;
                  best_len = len;
                  best_lo  = lo;
               end else if ((r.cmd == pgfs_pkg::FIT_BEST && len < best_len) ||
                            (r.cmd == pgfs_pkg::FIT_WORST && len > best_len)) begin
                  best_len = len;
                  best_lo  = lo;
               end
            end
         end
      end
      res.found     = have;
      res.gap_start = have ? best_lo[31:0] : '0;
      return res;
   endfunction

   function automatic alloc_req_type table4(input pgfs_pkg::fit_mode_type m, input longint rq,
                                            input longint s0, input longint z0,
                                            input longint s1, input longint z1,
                                            input longint s2, input longint z2,
                                            input longint s3, input longint z3);
      alloc_req_type r;
      r.cmd           = m;
      r.request_size  = rq[30:0];
      r.slot_start[0] = s0[30:0];
      r.slot_size[0]  = z0[30:0];
      r.slot_start[1] = s1[30:0];
      r.slot_size[1]  = z1[30:0];
      r.slot_start[2] = s2[30:0];
      r.slot_size[2]  = z2[30:0];
      r.slot_start[3] = s3[30:0];
      r.slot_size[3]  = z3[30:0];
      return r;
   endfunction

   // Drive one request, hold it until accepted, then queue its expected response.
   // Valid stays high afterwards so back-to-back requests need no bubble.
   task automatic send_request(input alloc_req_type r);
      int unsigned hold;
      hold = idle_length();
      if (hold != 0) begin
         req_bus.valid <= 1'b0;
         repeat (hold) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.cmd          <= r.cmd;
      req_bus.request_size <= r.request_size;
      req_bus.slot0_start  <= r.slot_start[0];
      req_bus.slot0_size   <= r.slot_size[0];
      req_bus.slot1_start  <= r.slot_start[1];
      req_bus.slot1_size   <= r.slot_size[1];
      req_bus.slot2_start  <= r.slot_start[2];
      req_bus.slot2_size   <= r.slot_size[2];
      req_bus.slot3_start  <= r.slot_start[3];
      req_bus.slot3_size   <= r.slot_size[3];
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      expected_gaps.push_back(predict_gap_choice(r));
   endtask

   // Drop valid, wait for every response, then let the pipeline empty out.
   task automatic settle_idle();
      req_bus.valid <= 1'b0;
      while (expected_gaps.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 4) @(posedge clock);
   endtask

   // Hold the write for one full cycle, starting and ending on a clock edge.
   task automatic write_csr(input logic [1:0] idx, input logic [30:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == pgfs_pkg::CSR_HEADER_SIZE) hdr_model = data[15:0];
      else if (idx == pgfs_pkg::CSR_DISK_SIZE) disk_model = data;
   endtask

   // Response side: random stalls while idle_on is set, checked against the oldest expectation.
   always @(posedge clock) begin
      int unsigned n;
      if (!idle_on) begin
         rsp_bus.ready <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left--;
      end else begin
         n = idle_length();
         rsp_bus.ready <= (n == 0);
         if (n != 0) stall_left = n - 1;
      end

      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_gaps.size() == 0) begin
            report_mismatch("response with no request outstanding");
         end else begin
            want = expected_gaps.pop_front();
            if (rsp_bus.found !== want.found)
               report_mismatch($sformatf("found %b, want %b", rsp_bus.found, want.found));
            if (rsp_bus.gap_start !== want.gap_start)
               report_mismatch($sformatf("gap_start %h, want %h",
                                         rsp_bus.gap_start, want.gap_start));
         end
      end
   end

   // Reset values: header 256, disk 0.
   task automatic test_reset_defaults();
      // Empty table: every gap runs from 256 down to 0, so nothing fits.
      send_request(table4(pgfs_pkg::FIT_FIRST, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      // Gap from the header end to slot 0.
      send_request(table4(pgfs_pkg::FIT_FIRST, 1, 1000, 0, 0, 0, 0, 0, 0, 0));
      settle_idle();
   endtask

   task automatic test_field_extremes();
      write_csr(pgfs_pkg::CSR_HEADER_SIZE, 31'd0);
      write_csr(pgfs_pkg::CSR_DISK_SIZE, BYTE_MAX);
      send_request(table4(pgfs_pkg::FIT_FIRST, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      // Largest request exactly equals the whole disk.
      send_request(table4(pgfs_pkg::FIT_BEST, BYTE_MAX, 0, 0, 0, 0, 0, 0, 0, 0));
      // Largest start and size push the cursor past the disk end.
      send_request(table4(pgfs_pkg::FIT_WORST, 1, BYTE_MAX, BYTE_MAX, 0, 0, 0, 0, 0, 0));
      settle_idle();
      write_csr(pgfs_pkg::CSR_HEADER_SIZE, 31'd65535);
      send_request(table4(pgfs_pkg::FIT_FIRST, BYTE_MAX, 0, 0, 0, 0, 0, 0, 0, 0));
      send_request(table4(pgfs_pkg::FIT_WORST, 0, BYTE_MAX, 0, 0, 0, 0, 0, 0, 0));
      settle_idle();
   endtask

   // Same table under every mode; gaps 744, 900, 2500, 3990, 10000.
   task automatic test_fit_modes();
      write_csr(pgfs_pkg::CSR_HEADER_SIZE, 31'd256);
      write_csr(pgfs_pkg::CSR_DISK_SIZE, 31'd20000);
      send_request(table4(pgfs_pkg::FIT_FIRST, 800, 1000, 100, 2000, 500, 5000, 10, 9000, 1000));
      send_request(table4(pgfs_pkg::FIT_BEST,  800, 1000, 100, 2000, 500, 5000, 10, 9000, 1000));
      send_request(table4(pgfs_pkg::FIT_WORST, 800, 1000, 100, 2000, 500, 5000, 10, 9000, 1000));
      send_request(table4(pgfs_pkg::FIT_NONE,  800, 1000, 100, 2000, 500, 5000, 10, 9000, 1000));
      settle_idle();
   endtask

   // Equal lengths: the earlier gap wins for both best and worst fit.
   task automatic test_ties();
      write_csr(pgfs_pkg::CSR_HEADER_SIZE, 31'd0);
      write_csr(pgfs_pkg::CSR_DISK_SIZE, 31'd1400);
      send_request(table4(pgfs_pkg::FIT_BEST,  50, 100, 100, 300, 100, 600, 0, 1000, 0));
      send_request(table4(pgfs_pkg::FIT_WORST, 50, 100, 100, 300, 100, 600, 0, 1000, 0));
      settle_idle();
   endtask

   task automatic test_special_cases();
      // Spare indexes must not disturb the registers.
      write_csr(CSR_SPARE_A, 31'h1234);
      write_csr(CSR_SPARE_B, 31'h7ABC_DEF0);
      // Unused slot in the middle keeps the cursor.
      send_request(table4(pgfs_pkg::FIT_FIRST, 300, 100, 100, 0, 500, 700, 50, 0, 0));
      // Overlapping, unsorted slots give negative gaps.
      send_request(table4(pgfs_pkg::FIT_WORST, 1, 500, 400, 600, 100, 800, 0, 0, 0));
      // Zero-length gap never qualifies, even for a zero request.
      send_request(table4(pgfs_pkg::FIT_BEST, 0, 100, 100, 200, 50, 260, 0, 0, 0));
      // No gap is big enough.
      send_request(table4(pgfs_pkg::FIT_FIRST, 5000, 100, 100, 200, 50, 260, 0, 0, 0));
      // Invalid mode with a table that would fit.
      send_request(table4(pgfs_pkg::FIT_NONE, 1, 100, 100, 0, 0, 0, 0, 0, 0));
      settle_idle();
   endtask

   // Ascending tables laid out from the header end, with requests near the gap sizes.
   task automatic run_random_phase(input logic [30:0] hdr_word, input logic [30:0] disk_word,
                                   input int count, input bit with_idle);
      alloc_req_type r;
      longint        pos, span, gap_len, slot_len;
      int unsigned   pick;
      settle_idle();
      write_csr(pgfs_pkg::CSR_HEADER_SIZE, hdr_word);
      write_csr(pgfs_pkg::CSR_DISK_SIZE, disk_word);
      idle_on = with_idle;
      repeat (count) begin
         pos  = hdr_model;
         span = (longint'(disk_model) - pos) / 6;
         if (span < 8) span = 8;
         gap_len = $urandom_range(0, span);
         for (int i = 0; i < pgfs_pkg::INPUT_SLOTS; i++) begin
            if ($urandom_range(0, 9) < 8) begin
               // Repeat the previous gap now and then to provoke ties.
               if ($urandom_range(0, 3) != 0) gap_len = $urandom_range(0, span);
               slot_len = $urandom_range(0, span);
               pos = pos + gap_len;
               r.slot_start[i] = pos[30:0];
               r.slot_size[i]  = slot_len[30:0];
               pos = pos + slot_len;
            end else begin
               r.slot_start[i] = '0;
               r.slot_size[i]  = 31'($urandom);
            end
         end
         pick = $urandom_range(0, 7);
         if (pick == 0) r.request_size = '0;
         else if (pick == 1) r.request_size = gap_len[30:0];
         else if (pick == 2) r.request_size = 31'(gap_len + 1);
         else r.request_size = 31'($urandom_range(0, 2 * span));
         if ($urandom_range(0, 9) == 0) r.cmd = pgfs_pkg::FIT_NONE;
         else r.cmd = pgfs_pkg::fit_mode_type'(2'($urandom_range(0, 2)));
         send_request(r);
      end
   endtask

   task automatic test_random_tables();
      run_random_phase(31'd256, 31'd1000000, 150, 1'b0);
      // Upper write bits beyond the header width must be dropped.
      run_random_phase(31'($urandom), 31'($urandom), 200, 1'b1);
      run_random_phase(31'd65535, BYTE_MAX, 150, 1'b1);
      run_random_phase(31'd0, 31'd5000, 150, 1'b1);
   endtask

   // Unconstrained fields, every bit toggled.
   task automatic test_noise();
      alloc_req_type r;
      settle_idle();
      write_csr(pgfs_pkg::CSR_HEADER_SIZE, 31'($urandom));
      write_csr(pgfs_pkg::CSR_DISK_SIZE, 31'($urandom));
      repeat (100) begin
         r.cmd          = pgfs_pkg::fit_mode_type'(2'($urandom_range(0, 3)));
         r.request_size = 31'($urandom);
         for (int i = 0; i < pgfs_pkg::INPUT_SLOTS; i++) begin
            r.slot_start[i] = 31'($urandom);
            r.slot_size[i]  = 31'($urandom);
         end
         send_request(r);
      end
   endtask

   initial begin
      reset                <= 1'b1;
      csr_we               <= 1'b0;
      csr_index            <= pgfs_pkg::CSR_HEADER_SIZE;
      csr_wdata            <= '0;
      req_bus.valid        <= 1'b0;
      req_bus.cmd          <= pgfs_pkg::FIT_FIRST;
      req_bus.request_size <= '0;
      req_bus.slot0_start  <= '0;
      req_bus.slot0_size   <= '0;
      req_bus.slot1_start  <= '0;
      req_bus.slot1_size   <= '0;
      req_bus.slot2_start  <= '0;
      req_bus.slot2_size   <= '0;
      req_bus.slot3_start  <= '0;
      req_bus.slot3_size   <= '0;
      hdr_model  = 16'd256;
      disk_model = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_field_extremes();
      test_fit_modes();
      test_ties();
      test_special_cases();
      test_random_tables();
      test_noise();

      settle_idle();
      idle_on = 1'b0;
      if (expected_gaps.size() != 0) report_mismatch("responses still outstanding");
      if (mismatch_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
